[hw/rtl/i2cfp_pkg.sv]
// Shared types and constants of the I2C flash-programming front end.
// Holds the event codes, register indexes and the beat structs of both channels.
// No dependencies.
package i2cfp_pkg;

  // bus event codes carried in func
  localparam logic [2:0] FUNC_ADDR_MATCH = 3'd0;
  localparam logic [2:0] FUNC_BYTE_WRITE = 3'd1;
  localparam logic [2:0] FUNC_BYTE_READ  = 3'd2;
  localparam logic [2:0] FUNC_STOP_WRITE = 3'd3;
  localparam logic [2:0] FUNC_STOP_READ  = 3'd4;
  localparam logic [2:0] FUNC_PROGRAM    = 3'd5;
  localparam logic [2:0] FUNC_ERASE_DONE = 3'd6;

  // configuration register indexes
  localparam logic CFG_FLASH_BASE  = 1'b0;
  localparam logic CFG_FLASH_BYTES = 1'b1;

  localparam logic [31:0] FLASH_BASE_RESET  = 32'd8192;
  localparam logic [31:0] FLASH_BYTES_RESET = 32'd253952;

  localparam int unsigned HEADER_BYTES = 4;
  localparam logic [7:0]  ERASE_CODE   = 8'hC7;
  localparam logic [7:0]  PAD_BYTE     = 8'hFF;
  localparam logic [31:0] WORD_MASK    = 32'hFFFF_FFFC;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic        ack;
    logic        read_from_flash;
    logic [31:0] read_addr;
    logic        word_valid;
    logic [31:0] word_addr;
    logic [31:0] word_data;
    logic        last;
    logic        erase_pending;
    logic        ready_res;
  } out_beat_t;

endpackage

[hw/rtl/i2cfp_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// Used for the byte store of the front end. No dependencies.
module i2cfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 260
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/i2c_flash_program_frontend_unit.sv]
// Top level of the I2C flash-programming front end: event sequencer around the byte store.
// Depends on i2cfp_pkg and i2cfp_ram.
//
//   channel   dir  handshake               payload
//   in        in   in_valid / in_ready     in_data  (in_beat_t)
//   out       out  out_valid / out_ready   out_data (out_beat_t)
//   cfg       in   cfg_we                  cfg_index, cfg_data
//
// One event at a time. A plain event is accepted, decoded and sent as a result beat;
// the last byte of a write header adds a pad state that writes as many pad bytes as
// the low two target address bits give; a stop after a write pads to a word (up to
// three pad bytes) and adds one bounds check. A program event reads the store via its
// single read port, one byte a cycle, pausing while a word beat waits for the output.
// Reset is synchronous; the byte store is not cleared. A stalled result beat holds in
// the output register while the next event is accepted and worked on.
module i2c_flash_program_frontend_unit
  import i2cfp_pkg::*;
#(
  parameter int BUF_BYTES = 260
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNT_W  = $clog2(BUF_BYTES + 1);
  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int WRD_W  = CNT_W - 2;
  localparam logic [CNT_W-1:0] BUF_FULL = CNT_W'(BUF_BYTES);
  localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(HEADER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_PAD_HDR, S_PAD_END, S_CHECK, S_FETCH, S_EMIT, S_RESULT
  } state_t;

  state_t            state;
  logic [2:0]        func;
  logic [7:0]        rx;
  logic [7:0]        hdr0, hdr1, hdr2;
  logic [31:0]       flash_base, flash_bytes;
  logic [32:0]       region_end;
  logic [CNT_W-1:0]  byte_count;
  logic [31:0]       flash_cursor;
  logic [CNT_W-1:0]  pending_len;
  logic              erase_flag;
  logic [1:0]        pad_left;
  logic              ack, rff;
  logic [31:0]       raddr;
  logic [WRD_W-1:0]  words_left;
  logic [31:0]       word_base;
  logic [31:0]       word_acc;
  logic [ADDR_W-1:0] rd_ptr;
  logic [2:0]        fetch_cnt;
  logic [1:0]        got_cnt;
  logic              rd_valid;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic              room;
  logic              slot_free;
  logic [31:0]       offset;
  logic [31:0]       cursor_next;
  logic [CNT_W-1:0]  data_len;
  logic [32:0]       write_end;

  assign in_ready    = (state == S_IDLE);
  assign room        = (byte_count < BUF_FULL);
  assign slot_free   = !out_valid || out_ready;
  assign offset      = {hdr0, hdr1, hdr2, rx};
  assign cursor_next = offset + flash_base;
  assign data_len    = byte_count - HDR_CNT;
  assign write_end   = {1'b0, flash_cursor} + {{(33 - CNT_W){1'b0}}, data_len};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = byte_count[ADDR_W-1:0];
    ram_wdata = PAD_BYTE;
    case (state)
      S_DECODE: begin
        if (func == FUNC_BYTE_WRITE && room) begin
          ram_we    = 1'b1;
          ram_wdata = rx;
        end
      end
      S_PAD_HDR: ram_we = (pad_left != 2'd0) && room;
      S_PAD_END: ram_we = (byte_count[1:0] != 2'd0) && room;
      default:   ram_we = 1'b0;
    endcase
  end

  assign ram_re = (state == S_FETCH) && (fetch_cnt != 3'd4);

  i2cfp_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      flash_base   <= FLASH_BASE_RESET;
      flash_bytes  <= FLASH_BYTES_RESET;
      region_end   <= {1'b0, FLASH_BASE_RESET} + {1'b0, FLASH_BYTES_RESET};
      byte_count   <= '0;
      flash_cursor <= '0;
      pending_len  <= '0;
      erase_flag   <= 1'b0;
      out_valid    <= 1'b0;
      rd_valid     <= 1'b0;
    end else begin
      region_end <= {1'b0, flash_base} + {1'b0, flash_bytes};
      rd_valid   <= ram_re;
      if (cfg_we) begin
        if (cfg_index == CFG_FLASH_BASE) begin
          flash_base <= cfg_data;
        end else begin
          flash_bytes <= cfg_data;
        end
      end
      // drop a taken beat; the beat states reload the register themselves
      if (out_valid && out_ready && state != S_EMIT && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func  <= in_data.func;
            rx    <= in_data.rx_byte;
            ack   <= 1'b0;
            rff   <= 1'b0;
            raddr <= '0;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          state <= S_RESULT;
          case (func)
            FUNC_ADDR_MATCH: ack <= !erase_flag && (pending_len == '0);
            FUNC_BYTE_WRITE: begin
              if (room) begin
                byte_count <= byte_count + 1'b1;
                ack        <= 1'b1;
                case (byte_count)
                  CNT_W'(0): hdr0 <= rx;
                  CNT_W'(1): hdr1 <= rx;
                  CNT_W'(2): hdr2 <= rx;
                  default: ;
                endcase
                // last header byte of a write: range-check and align
                if (byte_count == HDR_CNT - 1'b1 && !hdr0[7]) begin
                  if (offset >= flash_bytes) begin
                    ack <= 1'b0;
                  end else begin
                    flash_cursor <= cursor_next;
                    pad_left     <= cursor_next[1:0];
                    state        <= S_PAD_HDR;
                  end
                end
              end
            end
            FUNC_BYTE_READ: begin
              if ({1'b0, flash_cursor} < region_end) begin
                rff          <= 1'b1;
                raddr        <= flash_cursor;
                flash_cursor <= flash_cursor + 32'd1;
              end
            end
            FUNC_STOP_WRITE: begin
              if (byte_count != '0 && hdr0 == ERASE_CODE) begin
                erase_flag <= 1'b1;
                byte_count <= '0;
              end else if (!hdr0[7] && byte_count > HDR_CNT) begin
                state <= S_PAD_END;
              end else begin
                byte_count <= '0;
              end
            end
            FUNC_STOP_READ: flash_cursor <= flash_cursor - 32'd1;
            FUNC_PROGRAM: begin
              flash_cursor <= flash_cursor + {{(32 - CNT_W){1'b0}}, pending_len};
              pending_len  <= '0;
              word_base    <= flash_cursor & WORD_MASK;
              words_left   <= pending_len[CNT_W-1:2];
              rd_ptr       <= ADDR_W'(HEADER_BYTES);
              fetch_cnt    <= 3'd0;
              got_cnt      <= 2'd0;
              if (pending_len[CNT_W-1:2] != '0) begin
                state <= S_FETCH;
              end
            end
            FUNC_ERASE_DONE: erase_flag <= 1'b0;
            default: ;
          endcase
        end

        S_PAD_HDR: begin
          if (pad_left != 2'd0 && room) begin
            byte_count <= byte_count + 1'b1;
            pad_left   <= pad_left - 2'd1;
          end else begin
            state <= S_RESULT;
          end
        end

        S_PAD_END: begin
          if (byte_count[1:0] != 2'd0 && room) begin
            byte_count <= byte_count + 1'b1;
          end else begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (flash_cursor >= flash_base && write_end <= region_end) begin
            pending_len <= data_len;
          end
          byte_count <= '0;
          state      <= S_RESULT;
        end

        S_FETCH: begin
          if (fetch_cnt != 3'd4) begin
            rd_ptr    <= rd_ptr + 1'b1;
            fetch_cnt <= fetch_cnt + 3'd1;
          end
          // bytes arrive low first: shift in from the top
          if (rd_valid) begin
            word_acc <= {ram_rdata, word_acc[31:8]};
            got_cnt  <= got_cnt + 2'd1;
            if (got_cnt == 2'd3) begin
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            out_valid                <= 1'b1;
            out_data.ack             <= 1'b0;
            out_data.read_from_flash <= 1'b0;
            out_data.read_addr       <= '0;
            out_data.word_valid      <= 1'b1;
            out_data.word_addr       <= word_base;
            out_data.word_data       <= word_acc;
            out_data.last            <= (words_left == WRD_W'(1));
            out_data.erase_pending   <= erase_flag;
            out_data.ready_res       <= 1'b1;
            word_base                <= word_base + 32'd4;
            words_left               <= words_left - 1'b1;
            fetch_cnt                <= 3'd0;
            got_cnt                  <= 2'd0;
            state                    <= (words_left == WRD_W'(1)) ? S_IDLE : S_FETCH;
          end
        end

        S_RESULT: begin
          if (slot_free) begin
            out_valid                <= 1'b1;
            out_data.ack             <= ack;
            out_data.read_from_flash <= rff;
            out_data.read_addr       <= raddr;
            out_data.word_valid      <= 1'b0;
            out_data.word_addr       <= '0;
            out_data.word_data       <= '0;
            out_data.last            <= 1'b1;
            out_data.erase_pending   <= erase_flag;
            out_data.ready_res       <= !erase_flag && (pending_len == '0);
            state                    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/i2cfp_checker.sv]
// Port-level checker for the I2C flash-programming front end, with its bind.
// Depends on i2cfp_pkg and i2c_flash_program_frontend_unit.
module i2cfp_checker
  import i2cfp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // only word beats may leave the event open
  a_last_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.word_valid |-> out_data.last)
    else $error("non-word beat without last");

  a_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.word_valid |->
      !out_data.ack && !out_data.read_from_flash && out_data.ready_res &&
      out_data.word_addr[1:0] == 2'b00)
    else $error("malformed word beat");

  a_read_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_from_flash |-> out_data.read_addr == 32'd0)
    else $error("read address without flash read");

  a_erase_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.erase_pending && !out_data.word_valid |-> !out_data.ready_res)
    else $error("ready reported while erase pending");

endmodule

bind i2c_flash_program_frontend_unit i2cfp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
